FILE: rtl/multichannel_cross_correlator_defines.svh
// ----------------------------------------------------------------------------
// Multichannel cross-correlator assertion macros
// Shared assertion forms. They expect clk_i and rst_ni in the scope of use.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_CROSS_CORRELATOR_DEFINES_SVH
`define MULTICHANNEL_CROSS_CORRELATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcc: next-cycle check failed");

`endif

FILE: rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel cross-correlator package
// Item types, opcodes, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 40;
  localparam int POS_BITS    = 6;
  localparam int CHAN_BITS   = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;

  // Opcodes of an input item.
  localparam logic [1:0] OP_LOAD_KERNEL = 2'd0;
  localparam logic [1:0] OP_LOAD_IMAGE  = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_OUT_OF_PLANE = 2'd1;
  localparam logic [1:0] ST_KERNEL_LARGE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_KERNEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd6;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic [POS_BITS-1:0]           pos_x;
    logic [POS_BITS-1:0]           pos_y;
    logic [CHAN_BITS-1:0]          pos_z;
    logic signed [SAMPLE_BITS-1:0] value;
  } mcc_in_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [1:0]                 status;
  } mcc_out_t;

endpackage

`default_nettype wire

FILE: rtl/multichannel_cross_correlator.sv
// ----------------------------------------------------------------------------
// Multichannel 2D cross-correlator
// Image and kernel stores in RAM, one multiply-accumulate per kernel tap.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on in_valid_i/in_ready_o with an mcc_in_t payload.
// A kernel or image load is written straight into the matching store; loads
// outside the configured size are dropped silently.
// A compute item walks all kernel taps of all channels, one tap per cycle
// through the single port of each store, then a registered multiply and an
// accumulate stage, before its result is ready. A request that fails the size
// or position check goes straight to the done state and is answered with a
// zero sum. Only one item is worked on at a time. The input reopens in the
// cycle after a result is loaded, so loads are taken every cycle while the
// block is idle, and no new item is taken while a compute item is running.
// Result items leave on out_valid_o/out_ready_i from an output register, so
// loads keep flowing while a result waits; a finished compute holds until the
// output register frees up when the receiver stalls.
// Configuration registers are written through cfg_we_i with no handshake and
// must only change while the block is idle. Reset restores the register
// defaults; the stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_cross_correlator #(
  parameter int MAX_IMAGE_SIDE  = 32,
  parameter int MAX_KERNEL_SIDE = 8,
  parameter int MAX_CHANNELS    = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire mcc_pkg::mcc_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output mcc_pkg::mcc_out_t                    out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mcc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  `include "multichannel_cross_correlator_defines.svh"

  // Address field widths of the stores.
  localparam int XA = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;
  localparam int KA = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
  localparam int CA = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IMG_AW = CA + 2 * XA;
  localparam int KER_AW = CA + 2 * KA;
  localparam int IMG_DEPTH = 1 << IMG_AW;
  localparam int KER_DEPTH = 1 << KER_AW;
  // Coordinate arithmetic width, wide enough for sides and position sums.
  localparam int CrdW = $clog2(MAX_IMAGE_SIDE + 2 * MAX_KERNEL_SIDE + 64) + 1;
  localparam int CcW  = $clog2(MAX_CHANNELS + 1);
  localparam int SB   = mcc_pkg::SAMPLE_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // Configuration registers.
  logic       full_mode_q, flip_kernel_q;
  logic [5:0] image_width_q, image_height_q;
  logic [3:0] kernel_width_q, kernel_height_q;
  logic [2:0] channel_count_q;

  logic [1:0] state_q, state_d;
  logic [KA-1:0] tap_i_q, tap_i_d, tap_j_q, tap_j_d;
  logic [CA-1:0] tap_c_q, tap_c_d;
  logic [mcc_pkg::POS_BITS-1:0] x_q, y_q;
  logic [1:0] res_status_q;
  logic signed [mcc_pkg::SUM_BITS-1:0] acc_q;
  logic s1_vld_q, s2_vld_q;
  logic signed [2*SB-1:0] prod_q;
  logic out_valid_q;
  mcc_pkg::mcc_out_t out_data_q;

  // Effective (clamped) sizes.
  logic [CrdW-1:0] iw_e, ih_e, kw_e, kh_e, kwm1, khm1;
  logic [CcW-1:0]  cc_e;

  always_comb begin
    if (image_width_q == '0) begin
      iw_e = CrdW'(1);
    end else if (int'(image_width_q) > MAX_IMAGE_SIDE) begin
      iw_e = CrdW'(MAX_IMAGE_SIDE);
    end else begin
      iw_e = CrdW'(image_width_q);
    end
    if (image_height_q == '0) begin
      ih_e = CrdW'(1);
    end else if (int'(image_height_q) > MAX_IMAGE_SIDE) begin
      ih_e = CrdW'(MAX_IMAGE_SIDE);
    end else begin
      ih_e = CrdW'(image_height_q);
    end
    if (kernel_width_q == '0) begin
      kw_e = CrdW'(1);
    end else if (int'(kernel_width_q) > MAX_KERNEL_SIDE) begin
      kw_e = CrdW'(MAX_KERNEL_SIDE);
    end else begin
      kw_e = CrdW'(kernel_width_q);
    end
    if (kernel_height_q == '0) begin
      kh_e = CrdW'(1);
    end else if (int'(kernel_height_q) > MAX_KERNEL_SIDE) begin
      kh_e = CrdW'(MAX_KERNEL_SIDE);
    end else begin
      kh_e = CrdW'(kernel_height_q);
    end
    if (channel_count_q == '0) begin
      cc_e = CcW'(1);
    end else if (int'(channel_count_q) > MAX_CHANNELS) begin
      cc_e = CcW'(MAX_CHANNELS);
    end else begin
      cc_e = CcW'(channel_count_q);
    end
    kwm1 = kw_e - CrdW'(1);
    khm1 = kh_e - CrdW'(1);
  end

  // Input handshake and load decode.
  logic in_fire, is_load_img, is_load_ker, is_compute, load_in_range;
  logic img_we, ker_we;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_load_ker = in_fire && (in_data_i.opcode == mcc_pkg::OP_LOAD_KERNEL);
  assign is_load_img = in_fire && (in_data_i.opcode == mcc_pkg::OP_LOAD_IMAGE);
  assign is_compute  = in_fire && (in_data_i.opcode == mcc_pkg::OP_COMPUTE);

  logic img_in_range, ker_in_range, chan_in_range;
  assign chan_in_range = int'(in_data_i.pos_z) < int'(cc_e);
  assign img_in_range  = (CrdW'(in_data_i.pos_x) < iw_e) && (CrdW'(in_data_i.pos_y) < ih_e);
  assign ker_in_range  = (CrdW'(in_data_i.pos_x) < kw_e) && (CrdW'(in_data_i.pos_y) < kh_e);
  assign load_in_range = chan_in_range
                         && ((is_load_img && img_in_range) || (is_load_ker && ker_in_range));
  assign img_we = is_load_img && load_in_range;
  assign ker_we = is_load_ker && load_in_range;

  // Request check: kernel size first, then position against the output plane.
  logic [CrdW-1:0] ow, oh;
  logic [1:0]      req_status;

  always_comb begin
    ow = full_mode_q ? (iw_e + kwm1) : (iw_e - kwm1);
    oh = full_mode_q ? (ih_e + khm1) : (ih_e - khm1);
    priority if (!full_mode_q && ((kw_e > iw_e) || (kh_e > ih_e))) begin
      req_status = mcc_pkg::ST_KERNEL_LARGE;
    end else if ((CrdW'(in_data_i.pos_x) >= ow) || (CrdW'(in_data_i.pos_y) >= oh)) begin
      req_status = mcc_pkg::ST_OUT_OF_PLANE;
    end else begin
      req_status = mcc_pkg::ST_OK;
    end
  end

  // Tap address generation for the current kernel tap.
  logic [CrdW-1:0] sx, sy, ix, iy, kx, ky;
  logic            tap_ok, last_tap, tap_issue;

  always_comb begin
    sx = CrdW'(x_q) + CrdW'(tap_i_q);
    sy = CrdW'(y_q) + CrdW'(tap_j_q);
    if (full_mode_q) begin
      // Zero padding: the image position sits kernel-1 to the upper left.
      ix = sx - kwm1;
      iy = sy - khm1;
      tap_ok = (sx >= kwm1) && (sy >= khm1) && (ix < iw_e) && (iy < ih_e);
    end else begin
      ix = sx;
      iy = sy;
      tap_ok = 1'b1;
    end
    kx = flip_kernel_q ? (kwm1 - CrdW'(tap_i_q)) : CrdW'(tap_i_q);
    ky = flip_kernel_q ? (khm1 - CrdW'(tap_j_q)) : CrdW'(tap_j_q);
    last_tap = (CrdW'(tap_i_q) == kwm1) && (CrdW'(tap_j_q) == khm1)
               && (int'(tap_c_q) == int'(cc_e) - 1);
  end

  assign tap_issue = (state_q == S_RUN) && tap_ok;

  // Store ports: loads while idle, tap reads while running.
  logic [IMG_AW-1:0] img_addr;
  logic [KER_AW-1:0] ker_addr;
  logic [SB-1:0]     img_rdata, ker_rdata;

  always_comb begin
    if (state_q == S_RUN) begin
      img_addr = {tap_c_q, iy[XA-1:0], ix[XA-1:0]};
      ker_addr = {tap_c_q, ky[KA-1:0], kx[KA-1:0]};
    end else begin
      img_addr = {CA'(in_data_i.pos_z), XA'(in_data_i.pos_y), XA'(in_data_i.pos_x)};
      ker_addr = {CA'(in_data_i.pos_z), KA'(in_data_i.pos_y), KA'(in_data_i.pos_x)};
    end
  end

  mcc_ram #(
    .DATA_W (SB),
    .DEPTH  (IMG_DEPTH)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .addr_i  (img_addr),
    .wdata_i (in_data_i.value),
    .rdata_o (img_rdata)
  );

  mcc_ram #(
    .DATA_W (SB),
    .DEPTH  (KER_DEPTH)
  ) u_kernel_ram (
    .clk_i   (clk_i),
    .we_i    (ker_we),
    .addr_i  (ker_addr),
    .wdata_i (in_data_i.value),
    .rdata_o (ker_rdata)
  );

  // Sequencer.
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    tap_i_d = tap_i_q;
    tap_j_d = tap_j_q;
    tap_c_d = tap_c_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_compute) begin
          tap_i_d = '0;
          tap_j_d = '0;
          tap_c_d = '0;
          state_d = (req_status == mcc_pkg::ST_OK) ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        if (last_tap) begin
          state_d = S_DRAIN;
        end else if (CrdW'(tap_i_q) != kwm1) begin
          tap_i_d = tap_i_q + KA'(1);
        end else if (CrdW'(tap_j_q) != khm1) begin
          tap_i_d = '0;
          tap_j_d = tap_j_q + KA'(1);
        end else begin
          tap_i_d = '0;
          tap_j_d = '0;
          tap_c_d = tap_c_q + CA'(1);
        end
      end
      S_DRAIN: begin
        // Wait until the last product has been accumulated.
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_mode_q     <= 1'b0;
      flip_kernel_q   <= 1'b0;
      image_width_q   <= 6'd32;
      image_height_q  <= 6'd32;
      kernel_width_q  <= 4'd3;
      kernel_height_q <= 4'd3;
      channel_count_q <= 3'd1;
      state_q         <= S_IDLE;
      s1_vld_q        <= 1'b0;
      s2_vld_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mcc_pkg::CFG_FULL_MODE:     full_mode_q     <= cfg_data_i[0];
          mcc_pkg::CFG_FLIP_KERNEL:   flip_kernel_q   <= cfg_data_i[0];
          mcc_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i;
          mcc_pkg::CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i;
          mcc_pkg::CFG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data_i[3:0];
          mcc_pkg::CFG_KERNEL_HEIGHT: kernel_height_q <= cfg_data_i[3:0];
          mcc_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      state_q  <= state_d;
      s1_vld_q <= tap_issue;
      s2_vld_q <= s1_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: counters, request latch, multiply and accumulate.
  always_ff @(posedge clk_i) begin
    tap_i_q <= tap_i_d;
    tap_j_q <= tap_j_d;
    tap_c_q <= tap_c_d;
    if (is_compute) begin
      x_q          <= in_data_i.pos_x;
      y_q          <= in_data_i.pos_y;
      res_status_q <= req_status;
      acc_q        <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + mcc_pkg::SUM_BITS'(prod_q);
    end
    prod_q <= $signed(img_rdata) * $signed(ker_rdata);
    if (out_load) begin
      out_data_q.sum    <= acc_q;
      out_data_q.status <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks.
  `MCC_ASSERT_SAME(a_pipe_empty_idle, state_q == S_IDLE, !s1_vld_q && !s2_vld_q)
  `MCC_ASSERT_SAME(a_store_write_idle, img_we || ker_we, state_q == S_IDLE)
  `MCC_ASSERT_NEXT(a_result_loaded, out_load, out_valid_o && (state_q == S_IDLE))
  `MCC_ASSERT_SAME(a_error_zero_sum,
                   out_valid_o && (out_data_o.status != mcc_pkg::ST_OK),
                   out_data_o.sum == '0)

endmodule

`default_nettype wire

FILE: rtl/mcc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One optional write and one read per cycle at the same address; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]                      wdata_i,
  output logic      [DATA_W-1:0]                      rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire
